// ===== src/ggx_ndf_and_lambda_eval_unit_assert.svh =====
// Assertion macros shared by the GGX evaluator RTL.
// Depends on nothing; users must have signals named clk and rst in scope.
`ifndef GGX_NDF_AND_LAMBDA_EVAL_UNIT_ASSERT_SVH
`define GGX_NDF_AND_LAMBDA_EVAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GGX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ggx: same-cycle check failed");
`define GGX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ggx: next-cycle check failed");
`else
`define GGX_ASSERT_IMP(lbl, ante, cons)
`define GGX_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/ggx_pkg.sv =====
// Shared types, constants and pipeline depths of the GGX evaluator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ggx_pkg;

  // Fixed-point constants.
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [15:0] ALPHA_RESET = 16'd16384;

  // Request queue between front and back.
  localparam int              Q_DEPTH = 4;
  localparam int              Q_AW    = 2;
  localparam int              Q_CW    = 3;
  localparam logic [Q_CW-1:0] Q_FULL  = 3'd4;

  // Pipeline depths of the back end.
  localparam int PHI_LAT     = 30;   // cos2phi / sin2phi quotient bits
  localparam int DN_N        = 61;   // D path: sin2*phi / alpha^2 quotient bits
  localparam int RD_N        = 32;   // D path: reciprocal quotient bits
  localparam int DTERM_CORE  = 1 + DN_N + 7 + RD_N;
  localparam int LDIV_N      = 95;   // Lambda path: tan2 quotient bits
  localparam int SQ_N        = 48;   // Lambda path: square root bits
  localparam int LAMBDA_LAT  = 4 + LDIV_N + 1 + SQ_N + 1;
  localparam int D_PAD       = LAMBDA_LAT - DTERM_CORE;
  localparam int BACK_LAT    = PHI_LAT + LAMBDA_LAT;

  // Command codes.
  typedef enum logic {
    CMD_D      = 1'b0,
    CMD_LAMBDA = 1'b1
  } ggx_cmd_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_ALPHA_X = 1'b0,
    REG_ALPHA_Y = 1'b1
  } ggx_reg_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    ggx_cmd_t    cmd;
    logic        grazing;
    logic [30:0] x2;
    logic [30:0] y2;
    logic [30:0] z2;
    logic [30:0] sin2;
  } ggx_item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } ggx_qstat_t;

endpackage
`default_nettype wire

// ===== src/ggx_front.sv =====
// Front end: takes requests, squares the direction and flags grazing cases.
// Depends on ggx_pkg; feeds ggx_queue.
`timescale 1ns / 1ps
`default_nettype none
module ggx_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire logic                command,
  input  wire logic signed [15:0]  dir_x,
  input  wire logic signed [15:0]  dir_y,
  input  wire logic signed [15:0]  dir_z,
  input  wire ggx_pkg::ggx_qstat_t q_stat,
  output logic                     push,
  output ggx_pkg::ggx_item_t       push_item
);

  logic                      f_vld;
  ggx_pkg::ggx_item_t        f_item;
  ggx_pkg::ggx_item_t        nxt;
  logic signed [31:0]        sq_x;
  logic signed [31:0]        sq_y;
  logic signed [31:0]        sq_z;
  logic                      take;

  // The holding register is free when empty or when it moves into the queue.
  assign item_stall = f_vld & q_stat.full;
  assign push       = f_vld & ~q_stat.full;
  assign take       = item_valid & ~item_stall;
  assign push_item  = f_item;

  // Squares are Q2.30 and never exceed 2^30, so 31 bits hold them.
  assign sq_x = dir_x * dir_x;
  assign sq_y = dir_y * dir_y;
  assign sq_z = dir_z * dir_z;

  always_comb begin
    nxt.cmd     = ggx_pkg::ggx_cmd_t'(command);
    nxt.x2      = sq_x[30:0];
    nxt.y2      = sq_y[30:0];
    nxt.z2      = sq_z[30:0];
    nxt.sin2    = ggx_pkg::ONE_Q30 - sq_z[30:0];
    nxt.grazing = (sq_z[30:0] == 31'd0);
  end

  // Holding register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (take) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
  end

  // Holding register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      f_item <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/ggx_queue.sv =====
// Short request queue that decouples the front end from the back end.
// Depends on ggx_pkg and the shared assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "ggx_ndf_and_lambda_eval_unit_assert.svh"
module ggx_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ggx_pkg::ggx_item_t push_item,
  input  wire logic               pop,
  output ggx_pkg::ggx_item_t      pop_item,
  output ggx_pkg::ggx_qstat_t     stat
);

  ggx_pkg::ggx_item_t           ents [ggx_pkg::Q_DEPTH];
  logic [ggx_pkg::Q_AW-1:0]     wp;
  logic [ggx_pkg::Q_AW-1:0]     rp;
  logic [ggx_pkg::Q_CW-1:0]     cnt;

  assign stat.full  = (cnt == ggx_pkg::Q_FULL);
  assign stat.empty = (cnt == '0);
  assign pop_item   = ents[rp];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ents[wp] <= push_item;
    end
  end

  `GGX_ASSERT_IMP(a_no_push_full, push, !stat.full)
  `GGX_ASSERT_IMP(a_no_pop_empty, pop, !stat.empty)
  `GGX_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= ggx_pkg::Q_FULL)
  `GGX_ASSERT_NXT(a_cnt_up, push && !pop, cnt == $past(cnt) + 1'b1)

endmodule
`default_nettype wire

// ===== src/ggx_phi.sv =====
// Back end, first part: cos2phi and sin2phi by pipelined restoring division.
// Depends on ggx_pkg; feeds ggx_dterm and ggx_lambda.
`timescale 1ns / 1ps
`default_nettype none
module ggx_phi (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [30:0] x2,
  input  wire logic [30:0] y2,
  input  wire logic [30:0] sin2,
  input  wire logic [30:0] z2,
  output logic [30:0]      cp,
  output logic [30:0]      sp,
  output logic [30:0]      sin2_o,
  output logic [30:0]      z2_o
);

  localparam int N = ggx_pkg::PHI_LAT;

  logic [30:0] ra    [N];
  logic [30:0] rb    [N];
  logic [29:0] qa    [N];
  logic [29:0] qb    [N];
  logic [30:0] dd    [N];
  logic [30:0] zz    [N];
  logic [30:0] ra_i  [N];
  logic [30:0] rb_i  [N];
  logic [29:0] qa_i  [N];
  logic [29:0] qb_i  [N];
  logic [30:0] dd_i  [N];
  logic [31:0] sa    [N];
  logic [31:0] sb    [N];
  logic [N-1:0] clamp_a;
  logic [N-1:0] clamp_b;
  logic [N-1:0] zero_b;

  // One quotient bit: returns {bit, remainder}.
  function automatic logic [31:0] dstep(input logic [30:0] r, input logic [30:0] d);
    logic [31:0] t;
    logic [31:0] dv;
    t  = {r, 1'b0};
    dv = {1'b0, d};
    if (t >= dv) begin
      dstep = {1'b1, 31'(t - dv)};
    end else begin
      dstep = {1'b0, t[30:0]};
    end
  endfunction

  // Stage inputs: the first stage takes the request, the rest the stage before.
  always_comb begin
    ra_i[0] = x2;
    rb_i[0] = y2;
    qa_i[0] = '0;
    qb_i[0] = '0;
    dd_i[0] = sin2;
    for (int j = 1; j < N; j++) begin
      ra_i[j] = ra[j-1];
      rb_i[j] = rb[j-1];
      qa_i[j] = qa[j-1];
      qb_i[j] = qb[j-1];
      dd_i[j] = dd[j-1];
    end
    for (int j = 0; j < N; j++) begin
      sa[j] = dstep(ra_i[j], dd_i[j]);
      sb[j] = dstep(rb_i[j], dd_i[j]);
    end
  end

  // Division stages; z2 rides along for the later paths.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < N; j++) begin
        ra[j] <= sa[j][30:0];
        rb[j] <= sb[j][30:0];
        qa[j] <= {qa_i[j][28:0], sa[j][31]};
        qb[j] <= {qb_i[j][28:0], sb[j][31]};
        dd[j] <= dd_i[j];
      end
      zz[0] <= z2;
      for (int j = 1; j < N; j++) begin
        zz[j] <= zz[j-1];
      end
      clamp_a <= {clamp_a[N-2:0], x2 >= sin2};
      clamp_b <= {clamp_b[N-2:0], y2 >= sin2};
      zero_b  <= {zero_b[N-2:0], sin2 == 31'd0};
    end
  end

  // A ratio of one or more clamps to one; along the normal sin2phi is zero.
  assign cp     = clamp_a[N-1] ? ggx_pkg::ONE_Q30 : {1'b0, qa[N-1]};
  assign sp     = zero_b[N-1]  ? 31'd0 :
                  clamp_b[N-1] ? ggx_pkg::ONE_Q30 : {1'b0, qb[N-1]};
  assign sin2_o = dd[N-1];
  assign z2_o   = zz[N-1];

endmodule
`default_nettype wire

// ===== src/ggx_dterm.sv =====
// Back end, distribution D: normalized denominator and pipelined reciprocal.
// Depends on ggx_pkg; output is delayed to line up with ggx_lambda.
`timescale 1ns / 1ps
`default_nettype none
module ggx_dterm (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [30:0] cp,
  input  wire logic [30:0] sp,
  input  wire logic [30:0] sin2,
  input  wire logic [30:0] z2,
  input  wire logic [31:0] ax2,
  input  wire logic [31:0] ay2,
  input  wire logic [63:0] piaxay,
  output logic [31:0]      value,
  output logic             sat
);

  localparam int DN = ggx_pkg::DN_N;
  localparam int RN = ggx_pkg::RD_N;
  localparam int PN = ggx_pkg::D_PAD;

  logic [60:0]  nca;
  logic [60:0]  ncb;
  logic [30:0]  z1;
  logic [31:0]  ra   [DN];
  logic [31:0]  rb   [DN];
  logic [60:0]  na   [DN];
  logic [60:0]  nb   [DN];
  logic [30:0]  zd   [DN];
  logic [31:0]  ra_i [DN];
  logic [31:0]  rb_i [DN];
  logic [60:0]  na_i [DN];
  logic [60:0]  nb_i [DN];
  logic [30:0]  zd_i [DN];
  logic [32:0]  sa   [DN];
  logic [32:0]  sb   [DN];
  logic [61:0]  m;
  logic [61:0]  m_k;
  logic [4:0]   kk;
  logic [4:0]   k_k;
  logic [30:0]  mn;
  logic [4:0]   k_n;
  logic [61:0]  mn2;
  logic [4:0]   k_q;
  logic [63:0]  pp00;
  logic [63:0]  pp01;
  logic [63:0]  pp10;
  logic [63:0]  pp11;
  logic [4:0]   k_p;
  logic [127:0] den;
  logic [127:0] lim;
  logic         sat0;
  logic [127:0] r0;
  logic [127:0] den0;
  logic [127:0] rr    [RN];
  logic [127:0] dv    [RN];
  logic [31:0]  vv    [RN];
  logic         st    [RN];
  logic [127:0] rr_i  [RN];
  logic [127:0] dv_i  [RN];
  logic [31:0]  vv_i  [RN];
  logic         st_i  [RN];
  logic [127:0] rt    [RN];
  logic         rge   [RN];
  logic [32:0]  core;
  logic [32:0]  pad   [PN];

  // One quotient bit against a 32-bit divisor: returns {bit, remainder}.
  function automatic logic [32:0] dstep(input logic [31:0] r, input logic nbit,
                                        input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] dx;
    t  = {r, nbit};
    dx = {1'b0, d};
    if (t >= dx) begin
      dstep = {1'b1, 32'(t - dx)};
    end else begin
      dstep = {1'b0, t[31:0]};
    end
  endfunction

  // Stage inputs of the two alpha divisions.
  always_comb begin
    ra_i[0] = '0;
    rb_i[0] = '0;
    na_i[0] = nca;
    nb_i[0] = ncb;
    zd_i[0] = z1;
    for (int j = 1; j < DN; j++) begin
      ra_i[j] = ra[j-1];
      rb_i[j] = rb[j-1];
      na_i[j] = na[j-1];
      nb_i[j] = nb[j-1];
      zd_i[j] = zd[j-1];
    end
    for (int j = 0; j < DN; j++) begin
      sa[j] = dstep(ra_i[j], na_i[j][60], ax2);
      sb[j] = dstep(rb_i[j], nb_i[j][60], ay2);
    end
  end

  // Numerators, then one quotient bit per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      nca <= 61'(sin2 * cp);
      ncb <= 61'(sin2 * sp);
      z1  <= z2;
      for (int j = 0; j < DN; j++) begin
        ra[j] <= sa[j][31:0];
        rb[j] <= sb[j][31:0];
        na[j] <= {na_i[j][59:0], sa[j][32]};
        nb[j] <= {nb_i[j][59:0], sb[j][32]};
        zd[j] <= zd_i[j];
      end
    end
  end

  // Shift that keeps the top 31 bits of the denominator sum.
  always_comb begin
    kk = '0;
    for (int i = 0; i < 31; i++) begin
      if (m[31+i]) begin
        kk = 5'(i + 1);
      end
    end
  end

  // Sum, normalize, square and build the full denominator.
  always_ff @(posedge clk) begin
    if (adv) begin
      m    <= 62'({zd[DN-1], 2'b00}) + 62'(na[DN-1]) + 62'(nb[DN-1]);
      m_k  <= m;
      k_k  <= kk;
      mn   <= 31'(m_k >> k_k);
      k_n  <= k_k;
      mn2  <= 62'(mn * mn);
      k_q  <= k_n;
      pp00 <= mn2[31:0] * piaxay[31:0];
      pp01 <= mn2[31:0] * piaxay[63:32];
      pp10 <= 64'(mn2[61:32]) * piaxay[31:0];
      pp11 <= 64'(mn2[61:32]) * piaxay[63:32];
      k_p  <= k_q;
      den  <= 128'(pp00) + (128'(pp01) << 32) + (128'(pp10) << 32) + (128'(pp11) << 64);
      lim  <= 128'(1) << (7'd106 - {1'b0, k_p, 1'b0});
      sat0 <= (den <= lim);
      r0   <= lim;
      den0 <= den;
    end
  end

  // Reciprocal stages: 2^e / den, one quotient bit each.
  always_comb begin
    rr_i[0] = r0;
    dv_i[0] = den0;
    vv_i[0] = '0;
    st_i[0] = sat0;
    for (int j = 1; j < RN; j++) begin
      rr_i[j] = rr[j-1];
      dv_i[j] = dv[j-1];
      vv_i[j] = vv[j-1];
      st_i[j] = st[j-1];
    end
    for (int j = 0; j < RN; j++) begin
      rt[j]  = {rr_i[j][126:0], 1'b0};
      rge[j] = (dv_i[j] <= rt[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < RN; j++) begin
        rr[j] <= rge[j] ? rt[j] - dv_i[j] : rt[j];
        dv[j] <= dv_i[j];
        vv[j] <= {vv_i[j][30:0], rge[j]};
        st[j] <= st_i[j];
      end
    end
  end

  // Saturated results read all ones; then delay to the Lambda depth.
  assign core = {st[RN-1], st[RN-1] ? 32'hFFFF_FFFF : vv[RN-1]};

  always_ff @(posedge clk) begin
    if (adv) begin
      pad[0] <= core;
      for (int j = 1; j < PN; j++) begin
        pad[j] <= pad[j-1];
      end
    end
  end

  assign value = pad[PN-1][31:0];
  assign sat   = pad[PN-1][32];

endmodule
`default_nettype wire

// ===== src/ggx_lambda.sv =====
// Back end, Smith Lambda: tan2 quotient and pipelined integer square root.
// Depends on ggx_pkg; fed by ggx_phi.
`timescale 1ns / 1ps
`default_nettype none
module ggx_lambda (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [30:0] cp,
  input  wire logic [30:0] sp,
  input  wire logic [30:0] sin2,
  input  wire logic [30:0] z2,
  input  wire logic [31:0] ax2,
  input  wire logic [31:0] ay2,
  output logic [31:0]      value,
  output logic             sat
);

  localparam int LN = ggx_pkg::LDIV_N;
  localparam int SN = ggx_pkg::SQ_N;

  logic [62:0] pa;
  logic [62:0] pb;
  logic [30:0] s1_sin2;
  logic [30:0] s1_z2;
  logic [62:0] ws;
  logic [30:0] s2_sin2;
  logic [30:0] s2_z2;
  logic [62:0] plo;
  logic [61:0] phh;
  logic [30:0] s3_z2;
  logic [94:0] nm;
  logic [30:0] s4_z2;
  logic [30:0] rm   [LN];
  logic [94:0] nq   [LN];
  logic [30:0] zd   [LN];
  logic [30:0] rm_i [LN];
  logic [94:0] nq_i [LN];
  logic [30:0] zd_i [LN];
  logic [31:0] dt   [LN];
  logic        dge  [LN];
  logic [95:0] yv;
  logic [95:0] rr   [SN];
  logic [47:0] ss   [SN];
  logic [47:0] diff;

  // Tangent numerator: 4 * (cp*ax2 + sp*ay2) * sin2.
  always_ff @(posedge clk) begin
    if (adv) begin
      pa      <= 63'(cp * ax2);
      pb      <= 63'(sp * ay2);
      s1_sin2 <= sin2;
      s1_z2   <= z2;
      ws      <= pa + pb;
      s2_sin2 <= s1_sin2;
      s2_z2   <= s1_z2;
      plo     <= 63'(ws[31:0] * s2_sin2);
      phh     <= 62'(ws[62:32] * s2_sin2);
      s3_z2   <= s2_z2;
      nm      <= (95'(plo) + (95'(phh) << 32)) << 2;
      s4_z2   <= s3_z2;
    end
  end

  // Division by z2, one quotient bit per stage.
  always_comb begin
    rm_i[0] = '0;
    nq_i[0] = nm;
    zd_i[0] = s4_z2;
    for (int j = 1; j < LN; j++) begin
      rm_i[j] = rm[j-1];
      nq_i[j] = nq[j-1];
      zd_i[j] = zd[j-1];
    end
    for (int j = 0; j < LN; j++) begin
      dt[j]  = {rm_i[j], nq_i[j][94]};
      dge[j] = (dt[j] >= {1'b0, zd_i[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < LN; j++) begin
        rm[j] <= dge[j] ? 31'(dt[j] - {1'b0, zd_i[j]}) : dt[j][30:0];
        nq[j] <= {nq_i[j][93:0], dge[j]};
        zd[j] <= zd_i[j];
      end
      yv <= 96'(nq[LN-1]) + (96'(1) << 60);
    end
  end

  // Square root, one root bit per stage, most significant first.
  for (genvar j = 0; j < SN; j++) begin : g_sqrt
    logic [95:0] r_in;
    logic [47:0] s_in;
    logic [96:0] t;
    logic        ge;
    if (j == 0) begin : g_first
      assign r_in = yv;
      assign s_in = '0;
    end else begin : g_next
      assign r_in = rr[j-1];
      assign s_in = ss[j-1];
    end
    assign t  = (97'(s_in) << (SN - j)) + (97'(1) << (2 * (SN - 1 - j)));
    assign ge = (t <= 97'(r_in));
    always_ff @(posedge clk) begin
      if (adv) begin
        rr[j] <= ge ? 96'(97'(r_in) - t) : r_in;
        ss[j] <= ge ? (s_in | (48'(1) << (SN - 1 - j))) : s_in;
      end
    end
  end

  // Lambda = (sqrt(1 + a^2 tan^2) - 1) / 2, saturating at 32 bits.
  assign diff = ss[SN-1] - 48'(ggx_pkg::ONE_Q30);

  always_ff @(posedge clk) begin
    if (adv) begin
      sat   <= diff[47];
      value <= diff[47] ? 32'hFFFF_FFFF : diff[46:15];
    end
  end

endmodule
`default_nettype wire

// ===== src/ggx_ndf_and_lambda_eval_unit.sv =====
// Top level of the GGX evaluator: registers, front end, queue, back pipeline.
// Depends on ggx_pkg, ggx_front, ggx_queue, ggx_phi, ggx_dterm, ggx_lambda.
//
// Usage: a request (command, dir_x, dir_y, dir_z) is taken on a rising edge
// with item_valid high and item_stall low. Each request gives one result
// (value, saturated), taken on an edge with result_valid high and
// result_stall low. Results leave in request order.
// Path: a request passes the front register, the queue and the back entry
// register, then 179 stages of back pipeline (30 for the phi division, 149
// for the Lambda division and square root, which the D path is padded to
// match), then the output register.
// Throughput: one request per cycle, set by the fully pipelined dividers.
// A stalled result freezes the whole back pipeline; the queue and the front
// register keep taking up to five more requests before item_stall rises.
// Reset clears all valids and sets both roughness registers to 1.0.
// alpha_x and alpha_y are written through cfg_we/cfg_index/cfg_data by the
// user only while no request is in flight; the block does not enforce this.
// A zero roughness is used as the smallest step.
`timescale 1ns / 1ps
`default_nettype none
module ggx_ndf_and_lambda_eval_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic               command,
  input  wire logic signed [15:0] dir_x,
  input  wire logic signed [15:0] dir_y,
  input  wire logic signed [15:0] dir_z,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [31:0]             value,
  output logic                    saturated
);

  localparam int BL = ggx_pkg::BACK_LAT;

  logic [15:0]          alpha_x;
  logic [15:0]          alpha_y;
  logic [15:0]          ax_e;
  logic [15:0]          ay_e;
  logic [31:0]          ax2;
  logic [31:0]          ay2;
  logic [31:0]          axay;
  logic [63:0]          piaxay;
  logic                 push;
  ggx_pkg::ggx_item_t   push_item;
  ggx_pkg::ggx_item_t   pop_item;
  ggx_pkg::ggx_qstat_t  q_stat;
  logic                 pop;
  logic                 adv;
  logic                 b0_vld;
  ggx_pkg::ggx_item_t   b0;
  logic [BL-1:0]        vld_pipe;
  logic [BL-1:0]        cmd_pipe;
  logic [BL-1:0]        gz_pipe;
  logic [30:0]          cp;
  logic [30:0]          sp;
  logic [30:0]          sin2_p;
  logic [30:0]          z2_p;
  logic [31:0]          d_value;
  logic                 d_sat;
  logic [31:0]          l_value;
  logic                 l_sat;

  // Roughness registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_x <= ggx_pkg::ALPHA_RESET;
      alpha_y <= ggx_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ggx_pkg::REG_ALPHA_X: alpha_x <= cfg_data;
        ggx_pkg::REG_ALPHA_Y: alpha_y <= cfg_data;
      endcase
    end
  end

  // Roughness products: ax2, ay2 and axay are registered, piaxay from axay.
  assign ax_e = (alpha_x == 16'd0) ? 16'd1 : alpha_x;
  assign ay_e = (alpha_y == 16'd0) ? 16'd1 : alpha_y;

  always_ff @(posedge clk) begin
    ax2    <= ax_e * ax_e;
    ay2    <= ay_e * ay_e;
    axay   <= ax_e * ay_e;
    piaxay <= 64'(axay) * 64'(ggx_pkg::PI_Q30);
  end

  ggx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .q_stat     (q_stat),
    .push       (push),
    .push_item  (push_item)
  );

  ggx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  // The back pipeline moves whenever the output register can take a result.
  assign adv = ~result_valid | ~result_stall;
  assign pop = adv & ~q_stat.empty;

  // Back entry register.
  always_ff @(posedge clk) begin
    if (rst) begin
      b0_vld <= 1'b0;
    end else if (adv) begin
      b0_vld <= ~q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0 <= pop_item;
    end
  end

  ggx_phi u_phi (
    .clk    (clk),
    .adv    (adv),
    .x2     (b0.x2),
    .y2     (b0.y2),
    .sin2   (b0.sin2),
    .z2     (b0.z2),
    .cp     (cp),
    .sp     (sp),
    .sin2_o (sin2_p),
    .z2_o   (z2_p)
  );

  ggx_dterm u_dterm (
    .clk    (clk),
    .adv    (adv),
    .cp     (cp),
    .sp     (sp),
    .sin2   (sin2_p),
    .z2     (z2_p),
    .ax2    (ax2),
    .ay2    (ay2),
    .piaxay (piaxay),
    .value  (d_value),
    .sat    (d_sat)
  );

  ggx_lambda u_lambda (
    .clk   (clk),
    .adv   (adv),
    .cp    (cp),
    .sp    (sp),
    .sin2  (sin2_p),
    .z2    (z2_p),
    .ax2   (ax2),
    .ay2   (ay2),
    .value (l_value),
    .sat   (l_sat)
  );

  // Valid bits and request flags travel beside the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else if (adv) begin
      vld_pipe <= {vld_pipe[BL-2:0], b0_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_pipe <= {cmd_pipe[BL-2:0], b0.cmd == ggx_pkg::CMD_LAMBDA};
      gz_pipe  <= {gz_pipe[BL-2:0], b0.grazing};
    end
  end

  // Output register: grazing directions give zero for either command.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vld_pipe[BL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (gz_pipe[BL-1]) begin
        value     <= '0;
        saturated <= 1'b0;
      end else if (cmd_pipe[BL-1]) begin
        value     <= l_value;
        saturated <= l_sat;
      end else begin
        value     <= d_value;
        saturated <= d_sat;
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/ggx_ndf_and_lambda_eval_unit_tb.sv =====
// Self-checking testbench for the GGX distribution and Smith Lambda evaluator.
// Depends on ggx_pkg and ggx_ndf_and_lambda_eval_unit; compares every result
// against a bit-exact fixed-point predictor across several roughness settings.
`timescale 1ns / 1ps
module ggx_ndf_and_lambda_eval_unit_tb;
  import ggx_pkg::*;

  typedef struct {
    ggx_cmd_t          cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } dir_req_t;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } ggx_res_t;

  localparam logic [63:0] ONE30 = 64'd1 << 30;
  localparam logic [63:0] PI30  = 64'd3373259426;
  localparam int          DRAIN = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic               command = 1'b0;
  logic signed [15:0] dir_x = '0;
  logic signed [15:0] dir_y = '0;
  logic signed [15:0] dir_z = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [31:0]        value;
  logic               saturated;

  dir_req_t  pending_dirs[$];
  ggx_res_t  expected_results[$];
  logic [15:0] rough_x = ALPHA_RESET;
  logic [15:0] rough_y = ALPHA_RESET;
  bit        sender_hold = 1'b0;
  bit        no_idle = 1'b0;
  int        error_count = 0;
  int        results_seen = 0;
  int        rx_hold_left = 0;

  ggx_ndf_and_lambda_eval_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .command(command),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .result_valid(result_valid),
    .result_stall(result_stall), .value(value), .saturated(saturated)
  );

  always #1 clk = ~clk;

  // Bit-exact fixed-point evaluation of D or Lambda for one direction.
  function automatic ggx_res_t ggx_eval(input ggx_cmd_t cmd, input logic signed [15:0] dx,
                                        input logic signed [15:0] dy,
                                        input logic signed [15:0] dz,
                                        input logic [15:0] rx, input logic [15:0] ry);
    logic [63:0]  x2, y2, z2, ax, ay, ax2, ay2, sin2, cp, sp, m, mn, wsum, s, c, d;
    logic [127:0] den, lim, r, num, q, yv;
    int           len, k;
    ggx_res_t     res;
    x2 = 64'(longint'(dx) * longint'(dx));
    y2 = 64'(longint'(dy) * longint'(dy));
    z2 = 64'(longint'(dz) * longint'(dz));
    ax = (rx == 0) ? 64'd1 : 64'(rx);
    ay = (ry == 0) ? 64'd1 : 64'(ry);
    ax2 = ax * ax;
    ay2 = ay * ay;
    sin2 = (z2 < ONE30) ? ONE30 - z2 : 64'd0;
    // Along the normal the azimuth is undefined: take it as pure x.
    if (sin2 == 0) begin
      cp = ONE30;
      sp = 0;
    end else begin
      cp = (x2 << 30) / sin2;
      sp = (y2 << 30) / sin2;
      if (cp > ONE30) cp = ONE30;
      if (sp > ONE30) sp = ONE30;
    end
    res.value = '0;
    res.sat = 1'b0;
    // A grazing direction gives zero for both terms.
    if (z2 != 0) begin
      if (cmd == CMD_D) begin
        m = 4 * z2 + (sin2 * cp) / ax2 + (sin2 * sp) / ay2;
        len = 0;
        for (int i = 0; i < 64; i++) if (m[i]) len = i + 1;
        k = (len > 31) ? len - 31 : 0;
        mn = m >> k;
        den = 128'(mn * mn) * 128'(PI30 * ax * ay);
        lim = 128'd1 << (106 - 2 * k);
        if (den <= lim) begin
          res.value = '1;
          res.sat = 1'b1;
        end else begin
          // Restoring division of 2^(138-2k) by the denominator.
          r = lim;
          for (int i = 0; i < 32; i++) begin
            r = r << 1;
            res.value = {res.value[30:0], 1'b0};
            if (den <= r) begin
              r = r - den;
              res.value[0] = 1'b1;
            end
          end
        end
      end else begin
        wsum = cp * ax2 + sp * ay2;
        num = (128'(wsum) * 128'(sin2)) << 2;
        q = num / 128'(z2);
        yv = q + (128'd1 << 60);
        s = 0;
        for (int b = 47; b >= 0; b--) begin
          c = s | (64'd1 << b);
          if (128'(c) * 128'(c) <= yv) s = c;
        end
        d = (s - ONE30) >> 15;
        if (d > 64'hFFFF_FFFF) begin
          res.value = '1;
          res.sat = 1'b1;
        end else begin
          res.value = d[31:0];
        end
      end
    end
    return res;
  endfunction

  // Sender: offers queued requests and predicts each accepted one.
  always @(posedge clk) begin
    dir_req_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall)
        expected_results.push_back(ggx_eval(ggx_cmd_t'(command), dir_x, dir_y, dir_z,
                                            rough_x, rough_y));
      if (item_valid && item_stall) begin
        // A stalled request holds its payload.
      end else if (pending_dirs.size() > 0 && !sender_hold &&
                   (no_idle || $urandom_range(99) >= 33)) begin
        nxt = pending_dirs.pop_front();
        item_valid <= 1'b1;
        command <= nxt.cmd;
        dir_x <= nxt.x;
        dir_y <= nxt.y;
        dir_z <= nxt.z;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result and applies random and long stalls.
  always @(posedge clk) begin
    ggx_res_t exp_r;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%h saturated=%b", $realtime, value,
                   saturated);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (value !== exp_r.value) begin
            $display("%0t: value mismatch expected=%h actual=%h", $realtime, exp_r.value,
                     value);
            error_count++;
          end
          if (saturated !== exp_r.sat) begin
            $display("%0t: saturated mismatch expected=%b actual=%b", $realtime,
                     exp_r.sat, saturated);
            error_count++;
          end
        end
        // One long hold-off so the pipeline and queue fill up.
        if (results_seen == 400) rx_hold_left = 600;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !no_idle && ($urandom_range(99) < 33);
      end
    end
  end

  // Waits until every queued request is sent and every result has come back.
  task automatic drain_all();
    do @(posedge clk);
    while (pending_dirs.size() != 0 || item_valid || expected_results.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input ggx_reg_t idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ALPHA_X) rough_x = data;
    else rough_y = data;
  endtask

  task automatic add_dir(input ggx_cmd_t cmd, input int x, input int y, input int z);
    dir_req_t d;
    d.cmd = cmd;
    d.x = 16'(x);
    d.y = 16'(y);
    d.z = 16'(z);
    pending_dirs.push_back(d);
  endtask

  // Mostly unit directions, with raw noise, grazing and normal cases mixed in.
  task automatic add_random(input int count);
    int   kind, x, y, z;
    real  rest;
    ggx_cmd_t cmd;
    for (int n = 0; n < count; n++) begin
      cmd = ggx_cmd_t'($urandom_range(1));
      kind = $urandom_range(99);
      if (kind < 15) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end else if (kind < 20) begin
        x = $urandom;
        y = $urandom;
        z = (kind < 18) ? 0 : -32768;
      end else begin
        z = (kind < 40) ? $urandom_range(600) : $urandom_range(32767);
        rest = 1073741824.0 - real'(z) * real'(z);
        x = $urandom_range($rtoi($sqrt(rest)));
        y = $rtoi($sqrt(rest - real'(x) * real'(x)));
        if ($urandom_range(1)) x = -x;
        if ($urandom_range(1)) y = -y;
        if ($urandom_range(1)) z = -z;
        if ($urandom_range(1)) begin
          kind = x;
          x = y;
          y = kind;
        end
      end
      add_dir(cmd, x, y, z);
    end
  endtask

  // Stimulus phases, one per roughness setting.
  initial begin
    logic [15:0] ax_set[7];
    logic [15:0] ay_set[7];
    ax_set = '{16'd16384, 16'd1, 16'd65535, 16'd0, 16'd1, 16'd65535, 16'd4000};
    ay_set = '{16'd16384, 16'd1, 16'd65535, 16'd0, 16'd65535, 16'd1, 16'd9000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        write_reg(REG_ALPHA_X, ax_set[ph]);
        write_reg(REG_ALPHA_Y, ay_set[ph]);
      end else begin
        // Directed corners under the reset roughness.
        for (int c = 0; c < 2; c++) begin
          add_dir(ggx_cmd_t'(c), 32767, 0, 0);
          add_dir(ggx_cmd_t'(c), 0, 0, 32767);
          add_dir(ggx_cmd_t'(c), 0, 0, -32768);
          add_dir(ggx_cmd_t'(c), -32768, 0, 1);
          add_dir(ggx_cmd_t'(c), -32768, -32768, -32768);
          add_dir(ggx_cmd_t'(c), 23170, 0, 23170);
          add_dir(ggx_cmd_t'(c), 0, -23170, 23170);
          add_dir(ggx_cmd_t'(c), 32767, 32767, 32767);
          add_dir(ggx_cmd_t'(c), 0, 32767, 1);
          add_dir(ggx_cmd_t'(c), 18918, 18918, -18918);
        end
      end
      no_idle = (ph == 2);
      add_random(260);
      // Let part of the phase go out; in phase 4 also pause the sender until all is back.
      do @(posedge clk); while (pending_dirs.size() > 130);
      if (ph == 4) begin
        sender_hold = 1'b1;
        do @(posedge clk); while (item_valid || expected_results.size() != 0);
        sender_hold = 1'b0;
      end
      drain_all();
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
